FILE: rtl/bpe_pkg.sv
// Shared types and constants for the bivariate polynomial surface evaluator.
// Depends on nothing; imported by bivariate_polynomial_eval.
package bpe_pkg;

    // Command carried in s_tuser
    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_EVAL = 1'b1
    } cmd_e;

    // Field widths
    localparam int IDX_W   = 3;
    localparam int COEF_W  = 32;
    localparam int COORD_W = 16;
    localparam int POW_W   = 17;   // signed Q2.15, holds +1.0 exactly
    localparam int FRAC_SH = 15;

    // Input tdata layout, lowest bit first
    localparam int IDX_LSB   = 0;
    localparam int COEF_LSB  = IDX_LSB + IDX_W;
    localparam int X_LSB     = COEF_LSB + COEF_W;
    localparam int Y_LSB     = X_LSB + COORD_W;
    localparam int S_FIELD_W = Y_LSB + COORD_W;
    localparam int S_DATA_W  = ((S_FIELD_W + 7) / 8) * 8;
    localparam int M_DATA_W  = COEF_W;

    // 1.0 in Q2.15
    localparam logic signed [POW_W-1:0] ONE_Q15 = 17'sd32768;

    // Saturation limits of the Q16.16 result
    localparam logic [COEF_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [COEF_W-1:0] SAT_MIN = 32'h8000_0000;

endpackage

FILE: rtl/bivariate_polynomial_eval.sv
// Bivariate polynomial surface evaluator: pipelined powers, monomials,
// coefficient products, registered adder tree and saturating output stage.
// Depends on bpe_pkg.
//
// Throughput: one item per cycle unless every stage is full and m_tready
// is low; the depth is set by the power multiplier chain (one stage per
// power) and the adder tree. A stall only holds full stages; bubbles are
// squeezed out, so input is taken while a result waits if some stage is
// empty. Load items write the coefficient table in order and give no
// result. Reset clears all stage valid bits; the table is not reset.
module bivariate_polynomial_eval
    import bpe_pkg::*;
#(
    parameter int DEGREE = 2
) (
    input  logic                aclk,
    input  logic                aresetn,
    // input item
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // coef_index[2:0], coef_value[34:3],
                                           // x_in[50:35], y_in[66:51], zero pad
    input  logic [0:0]          s_tuser,   // cmd[0]
    // result item
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // surface_value[31:0]
    output logic [0:0]          m_tuser    // saturated[0]
);

    localparam int NTERMS   = ((DEGREE + 1) * (DEGREE + 2)) / 2;
    localparam int TREE_L   = $clog2(NTERMS);
    localparam int TREE_N   = 1 << TREE_L;
    localparam int PROD_W   = COEF_W + POW_W;
    localparam int ACC_W    = PROD_W + TREE_L;
    localparam int MONO_ST  = DEGREE + 1;
    localparam int PROD_ST  = DEGREE + 2;
    localparam int OUT_ST   = PROD_ST + TREE_L + 1;
    localparam int NST      = OUT_ST + 1;
    localparam int SUM_MSB  = FRAC_SH + COEF_W - 1;

    // Stage control
    logic [NST-1:0] v_reg;
    logic [NST-1:0] stage_en;

    // Command payload, carried to the monomial stage
    cmd_e                      cmd_reg  [0:MONO_ST];
    logic [IDX_W-1:0]          idx_reg  [0:MONO_ST];
    logic signed [COEF_W-1:0]  coef_reg [0:MONO_ST];

    // Coordinates, carried through the power stages
    logic signed [COORD_W-1:0] x_reg [0:DEGREE-1];
    logic signed [COORD_W-1:0] y_reg [0:DEGREE-1];

    // Power vectors per stage; stage s holds powers 0..s
    logic signed [POW_W-1:0]   xp_reg [0:DEGREE][0:DEGREE];
    logic signed [POW_W-1:0]   yp_reg [0:DEGREE][0:DEGREE];
    logic signed [POW_W+COORD_W-1:0] xmul [1:DEGREE];
    logic signed [POW_W+COORD_W-1:0] ymul [1:DEGREE];

    // Monomials, products and adder tree
    logic signed [2*POW_W-1:0] mmul     [0:NTERMS-1];
    logic signed [POW_W-1:0]   mono_reg [0:NTERMS-1];
    logic signed [PROD_W-1:0]  pmul     [0:NTERMS-1];
    logic signed [ACC_W-1:0]   tr_reg   [0:TREE_L][0:TREE_N-1];

    // Coefficient table, undefined until written
    logic signed [COEF_W-1:0]  coef_tab_reg [0:NTERMS-1];

    // Output stage
    logic [COEF_W-1:0] out_data_reg, out_data_next;
    logic              out_sat_reg,  out_sat_next;
    logic [ACC_W-SUM_MSB-1:0] sum_hi;

    // Backward ready chain: a stage moves when empty or when the next one moves
    always_comb begin
        stage_en[NST-1] = !v_reg[NST-1] || m_tready;
        for (int s = NST - 2; s >= 0; s--) begin
            stage_en[s] = !v_reg[s] || stage_en[s+1];
        end
    end

    assign s_tready = stage_en[0];

    // Valid bits; load items end at the monomial stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (stage_en[0]) begin
                v_reg[0] <= s_tvalid;
            end
            for (int s = 1; s < NST; s++) begin
                if (stage_en[s]) begin
                    if (s == PROD_ST) begin
                        v_reg[s] <= v_reg[s-1] && (cmd_reg[MONO_ST] == CMD_EVAL);
                    end else begin
                        v_reg[s] <= v_reg[s-1];
                    end
                end
            end
        end
    end

    // Input stage and command payload
    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            cmd_reg[0]  <= cmd_e'(s_tuser[0]);
            idx_reg[0]  <= s_tdata[IDX_LSB +: IDX_W];
            coef_reg[0] <= s_tdata[COEF_LSB +: COEF_W];
            x_reg[0]    <= s_tdata[X_LSB +: COORD_W];
            y_reg[0]    <= s_tdata[Y_LSB +: COORD_W];
        end
        for (int s = 1; s <= MONO_ST; s++) begin
            if (stage_en[s]) begin
                cmd_reg[s]  <= cmd_reg[s-1];
                idx_reg[s]  <= idx_reg[s-1];
                coef_reg[s] <= coef_reg[s-1];
            end
        end
        for (int s = 1; s < DEGREE; s++) begin
            if (stage_en[s]) begin
                x_reg[s] <= x_reg[s-1];
                y_reg[s] <= y_reg[s-1];
            end
        end
    end

    // Power stages: stage s forms power s from power s-1
    always_comb begin
        for (int s = 1; s <= DEGREE; s++) begin
            xmul[s] = xp_reg[s-1][s-1] * x_reg[s-1];
            ymul[s] = yp_reg[s-1][s-1] * y_reg[s-1];
        end
    end

    always_ff @(posedge aclk) begin
        // stage 0 starts with power 0 = 1.0
        if (stage_en[0]) begin
            for (int k = 0; k <= DEGREE; k++) begin
                xp_reg[0][k] <= (k == 0) ? ONE_Q15 : '0;
                yp_reg[0][k] <= (k == 0) ? ONE_Q15 : '0;
            end
        end
        for (int s = 1; s <= DEGREE; s++) begin
            if (stage_en[s]) begin
                for (int k = 0; k <= DEGREE; k++) begin
                    if (k == s) begin
                        xp_reg[s][k] <= xmul[s][FRAC_SH +: POW_W];
                        yp_reg[s][k] <= ymul[s][FRAC_SH +: POW_W];
                    end else begin
                        xp_reg[s][k] <= xp_reg[s-1][k];
                        yp_reg[s][k] <= yp_reg[s-1][k];
                    end
                end
            end
        end
    end

    // Monomials x^i*y^j, i outer and j inner
    always_comb begin
        int t;
        t = 0;
        for (int i = 0; i <= DEGREE; i++) begin
            for (int j = 0; j <= DEGREE - i; j++) begin
                mmul[t] = xp_reg[DEGREE][i] * yp_reg[DEGREE][j];
                t++;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[MONO_ST]) begin
            for (int t = 0; t < NTERMS; t++) begin
                mono_reg[t] <= mmul[t][FRAC_SH +: POW_W];
            end
        end
    end

    // Table write as a load leaves the monomial stage, so it is ordered
    // against evaluate items, which read the table at the same step
    always_ff @(posedge aclk) begin
        if (v_reg[MONO_ST] && cmd_reg[MONO_ST] == CMD_LOAD && stage_en[PROD_ST]) begin
            for (int t = 0; t < NTERMS; t++) begin
                if ({1'b0, idx_reg[MONO_ST]} == 4'(t)) begin
                    coef_tab_reg[t] <= coef_reg[MONO_ST];
                end
            end
        end
    end

    // Coefficient products
    always_comb begin
        for (int t = 0; t < NTERMS; t++) begin
            pmul[t] = coef_tab_reg[t] * mono_reg[t];
        end
    end

    // Product stage and registered adder tree
    always_ff @(posedge aclk) begin
        if (stage_en[PROD_ST]) begin
            for (int t = 0; t < NTERMS; t++) begin
                tr_reg[0][t] <= ACC_W'(pmul[t]);
            end
            for (int t = NTERMS; t < TREE_N; t++) begin
                tr_reg[0][t] <= '0;
            end
        end
        for (int l = 1; l <= TREE_L; l++) begin
            if (stage_en[PROD_ST+l]) begin
                for (int n = 0; n < (TREE_N >> l); n++) begin
                    tr_reg[l][n] <= tr_reg[l-1][2*n] + tr_reg[l-1][2*n+1];
                end
            end
        end
    end

    // Shift to Q16.16 (floor) and clamp
    assign sum_hi = tr_reg[TREE_L][0][ACC_W-1:SUM_MSB];

    always_comb begin
        if ((&sum_hi) || !(|sum_hi)) begin
            out_data_next = tr_reg[TREE_L][0][SUM_MSB:FRAC_SH];
            out_sat_next  = 1'b0;
        end else begin
            out_data_next = tr_reg[TREE_L][0][ACC_W-1] ? SAT_MIN : SAT_MAX;
            out_sat_next  = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[OUT_ST]) begin
            out_data_reg <= out_data_next;
            out_sat_reg  <= out_sat_next;
        end
    end

    assign m_tvalid   = v_reg[OUT_ST];
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_sat_reg;

    // Input is refused only when every stage holds an item
    a_full_when_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (&v_reg))
        else $error("input stalled with an empty stage");

    // A load item never enters the product stage
    a_load_dropped: assert property (@(posedge aclk) disable iff (!aresetn)
        (v_reg[MONO_ST] && cmd_reg[MONO_ST] == CMD_LOAD && stage_en[PROD_ST])
        |=> !v_reg[PROD_ST])
        else $error("load item passed into the product stage");

    // The saturation flag only comes with a clamped value
    a_sat_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == SAT_MAX || m_tdata == SAT_MIN))
        else $error("saturated flag without a clamped value");

    // Reset empties the output stage
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule
